// ----- rtl/core/br1_pkg.sv -----
// shared types and constants for the byterun1 bitplane decoder
// no dependencies; used by the register block, the decode core and the top level

package br1_pkg;

    localparam int CfgAddrWidth = 4;

    typedef enum logic [1:0] {
        REG_COMPRESS_MODE = 2'd0,
        REG_ROW_BYTES     = 2'd1,
        REG_PLANE_COUNT   = 2'd2,
        REG_ROW_COUNT     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    typedef struct packed {
        logic        compress_mode;
        logic [11:0] row_bytes;
        logic [3:0]  plane_count;
        logic [11:0] row_count;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  plane_index;
        logic [11:0] row_index;
        logic [11:0] start_column;
        logic [7:0]  fill_value;
        logic [7:0]  repeat_count;
        logic        row_done;
        logic        image_done;
        logic        overrun;
    } wdesc_t;

endpackage

// ----- rtl/core/br1_byte_if.sv -----
// valid/ready channel carrying one body byte per item
// no dependencies

interface br1_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;

    modport source (output valid, output body_byte, input ready);
    modport sink (input valid, input body_byte, output ready);
endinterface

// ----- rtl/core/br1_wdesc_if.sv -----
// valid/ready channel carrying one write descriptor per item
// no dependencies

interface br1_wdesc_if;
    logic        valid;
    logic        ready;
    logic [2:0]  plane_index;
    logic [11:0] row_index;
    logic [11:0] start_column;
    logic [7:0]  fill_value;
    logic [7:0]  repeat_count;
    logic        row_done;
    logic        image_done;
    logic        overrun;

    modport source (
        output valid, output plane_index, output row_index, output start_column,
        output fill_value, output repeat_count, output row_done, output image_done,
        output overrun, input ready
    );
    modport sink (
        input valid, input plane_index, input row_index, input start_column,
        input fill_value, input repeat_count, input row_done, input image_done,
        input overrun, output ready
    );
endinterface

// ----- rtl/core/br1_cfg_regs.sv -----
// apb configuration registers: compress mode, row bytes, plane count, row count
// depends on br1_pkg

module br1_cfg_regs
    import br1_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    // low address bits are ignored, registers sit on word boundaries
    assign reg_sel = reg_index_t'(paddr[CfgAddrWidth-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_COMPRESS_MODE: cfg_next.compress_mode = pwdata[0];
                REG_ROW_BYTES:     cfg_next.row_bytes     = pwdata[11:0];
                REG_PLANE_COUNT:   cfg_next.plane_count   = pwdata[3:0];
                REG_ROW_COUNT:     cfg_next.row_count     = pwdata[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_COMPRESS_MODE: prdata = {31'd0, cfg_reg.compress_mode};
            REG_ROW_BYTES:     prdata = {20'd0, cfg_reg.row_bytes};
            REG_PLANE_COUNT:   prdata = {28'd0, cfg_reg.plane_count};
            REG_ROW_COUNT:     prdata = {20'd0, cfg_reg.row_count};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compress_mode <= 1'b1;
            cfg_reg.row_bytes     <= 12'd40;
            cfg_reg.plane_count   <= 4'd5;
            cfg_reg.row_count     <= 12'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/br1_decode_core.sv -----
// decode core: input register, phase and position state, result register
// depends on br1_pkg, br1_byte_if and br1_wdesc_if

module br1_decode_core
    import br1_pkg::*;
#(
    parameter int MAX_PLANES    = 8,
    parameter int MAX_ROW_BYTES = 4095
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    br1_byte_if.sink    body,
    br1_wdesc_if.source wdesc
);

    localparam logic [11:0] MaxRowBytes = 12'(MAX_ROW_BYTES);
    localparam logic [3:0]  MaxPlanes   = 4'(MAX_PLANES);

    // input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // decode state
    phase_t      phase_reg, phase_next;
    logic [7:0]  literal_left_reg, literal_left_next;
    logic [7:0]  pending_repeat_reg, pending_repeat_next;
    logic [11:0] column_pos_reg, column_pos_next;
    logic [2:0]  plane_pos_reg, plane_pos_next;
    logic [11:0] row_pos_reg, row_pos_next;
    logic        finished_reg, finished_next;

    // result stage
    logic   out_valid_reg, out_valid_next;
    wdesc_t desc_reg, desc_next;

    logic advance;
    logic body_fire;
    logic step;

    // effective configuration
    logic [11:0] rb_eff;
    logic [3:0]  planes_eff;
    logic [11:0] rows_eff;

    // write computation
    logic        active;
    logic        emit_go;
    logic [7:0]  want;
    logic [7:0]  literal_dec;
    logic        lit_more;
    logic        col_in_row;
    logic [11:0] room;
    logic        over_room;
    logic        rdone;
    logic [7:0]  cnt;
    logic [11:0] column_after;
    logic [2:0]  plane_inc;
    logic        plane_wrap;
    logic [11:0] row_inc;
    logic        idone;

    assign advance   = !out_valid_reg || wdesc.ready;
    assign body.ready = !in_valid_reg || advance;
    assign body_fire = body.valid && body.ready;
    assign step      = in_valid_reg && advance;

    always_comb
    begin
        if (cfg.row_bytes == 12'd0)
            rb_eff = 12'd1;
        else if (cfg.row_bytes > MaxRowBytes)
            rb_eff = MaxRowBytes;
        else
            rb_eff = cfg.row_bytes;

        if (cfg.plane_count == 4'd0)
            planes_eff = 4'd1;
        else if (cfg.plane_count > MaxPlanes)
            planes_eff = MaxPlanes;
        else
            planes_eff = cfg.plane_count;

        rows_eff = (cfg.row_count == 12'd0) ? 12'd1 : cfg.row_count;
    end

    // shared write arithmetic, used by every kind of write
    always_comb
    begin
        literal_dec  = literal_left_reg - 8'd1;
        want         = (cfg.compress_mode && phase_reg == PH_REPEAT) ? pending_repeat_reg : 8'd1;
        lit_more     = cfg.compress_mode && phase_reg == PH_LITERAL && literal_dec != 8'd0;
        col_in_row   = column_pos_reg < rb_eff;
        room         = col_in_row ? (rb_eff - column_pos_reg) : 12'd1;
        over_room    = {4'd0, want} > room;
        // a column already past the row end always closes the row
        rdone        = !col_in_row || ({4'd0, want} >= room);
        cnt          = over_room ? room[7:0] : want;
        column_after = rdone ? 12'd0 : (column_pos_reg + {4'd0, want});
        plane_inc    = plane_pos_reg + 3'd1;
        plane_wrap   = ({1'b0, plane_inc} >= planes_eff) || (plane_inc == 3'd0);
        row_inc      = row_pos_reg + 12'd1;
        idone        = rdone && plane_wrap && (row_inc >= rows_eff);
    end

    // output decode: does this item make a write
    always_comb
    begin
        active  = step && !finished_reg && (row_pos_reg < rows_eff);
        emit_go = 1'b0;
        if (active)
        begin
            if (!cfg.compress_mode)
                emit_go = 1'b1;
            else
            begin
                case (phase_reg)
                    PH_LITERAL, PH_REPEAT: emit_go = 1'b1;
                    default:               emit_go = 1'b0;
                endcase
            end
        end

        desc_next.plane_index  = plane_pos_reg;
        desc_next.row_index    = row_pos_reg;
        desc_next.start_column = column_pos_reg;
        desc_next.fill_value   = in_byte_reg;
        desc_next.repeat_count = cnt;
        desc_next.row_done     = rdone;
        desc_next.image_done   = idone;
        desc_next.overrun      = over_room || (rdone && lit_more);
    end

    // next state
    always_comb
    begin
        phase_next          = phase_reg;
        literal_left_next   = literal_left_reg;
        pending_repeat_next = pending_repeat_reg;
        column_pos_next     = column_pos_reg;
        plane_pos_next      = plane_pos_reg;
        row_pos_next        = row_pos_reg;
        finished_next       = finished_reg;

        if (step && !finished_reg && !(row_pos_reg < rows_eff))
            finished_next = 1'b1;

        if (active)
        begin
            if (!cfg.compress_mode)
            begin
                phase_next          = PH_HEADER;
                literal_left_next   = 8'd0;
                pending_repeat_next = 8'd0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LITERAL:
                    begin
                        literal_left_next = literal_dec;
                        if (literal_dec == 8'd0)
                            phase_next = PH_HEADER;
                        else if (rdone)
                            phase_next = PH_DISCARD;
                    end
                    PH_REPEAT:
                    begin
                        pending_repeat_next = 8'd0;
                        phase_next          = PH_HEADER;
                    end
                    PH_DISCARD:
                    begin
                        literal_left_next = literal_dec;
                        if (literal_dec == 8'd0)
                            phase_next = PH_HEADER;
                    end
                    PH_HEADER:
                    begin
                        // 0x80 is the no-op header
                        if (!in_byte_reg[7])
                        begin
                            literal_left_next = in_byte_reg + 8'd1;
                            phase_next        = PH_LITERAL;
                        end
                        else if (in_byte_reg != 8'h80)
                        begin
                            pending_repeat_next = 8'(9'd257 - {1'b0, in_byte_reg});
                            phase_next          = PH_REPEAT;
                        end
                    end
                    default: phase_next = PH_HEADER;
                endcase
            end
        end

        if (emit_go)
        begin
            column_pos_next = column_after;
            if (rdone)
            begin
                plane_pos_next = plane_wrap ? 3'd0 : plane_inc;
                if (plane_wrap)
                    row_pos_next = row_inc;
                if (idone)
                    finished_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (body_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        out_valid_next = advance ? emit_go : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_HEADER;
            literal_left_reg   <= 8'd0;
            pending_repeat_reg <= 8'd0;
            column_pos_reg     <= 12'd0;
            plane_pos_reg      <= 3'd0;
            row_pos_reg        <= 12'd0;
            finished_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg       <= in_valid_next;
            out_valid_reg      <= out_valid_next;
            phase_reg          <= phase_next;
            literal_left_reg   <= literal_left_next;
            pending_repeat_reg <= pending_repeat_next;
            column_pos_reg     <= column_pos_next;
            plane_pos_reg      <= plane_pos_next;
            row_pos_reg        <= row_pos_next;
            finished_reg       <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (body_fire)
            in_byte_reg <= body.body_byte;
        if (advance && emit_go)
            desc_reg <= desc_next;
    end

    assign wdesc.valid        = out_valid_reg;
    assign wdesc.plane_index  = desc_reg.plane_index;
    assign wdesc.row_index    = desc_reg.row_index;
    assign wdesc.start_column = desc_reg.start_column;
    assign wdesc.fill_value   = desc_reg.fill_value;
    assign wdesc.repeat_count = desc_reg.repeat_count;
    assign wdesc.row_done     = desc_reg.row_done;
    assign wdesc.image_done   = desc_reg.image_done;
    assign wdesc.overrun      = desc_reg.overrun;

endmodule

// ----- rtl/core/byterun1_bitplane_decoder.sv -----
// ByteRun1 / raw bitplane body decoder. Takes one body byte per item and
// gives at most one write descriptor (plane, row, start column, value,
// repeat count, row/image done, overrun) per byte. Throughput is one item
// per clock unless wdesc.ready stalls the output: each byte passes an input
// register, one pass of phase and counter logic, and a result register, from
// which its write is given. Header bytes, discarded literal bytes and bytes
// after the image end give no write. body.ready follows wdesc.ready
// combinationally through the two register stages. Registers are to be written
// over the apb port only while the block is idle; the block does not enforce it.
// depends on br1_pkg, br1_byte_if, br1_wdesc_if, br1_cfg_regs, br1_decode_core

module byterun1_bitplane_decoder
    import br1_pkg::*;
#(
    parameter int MAX_PLANES    = 8,
    parameter int MAX_ROW_BYTES = 4095
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    br1_byte_if.sink                body,
    br1_wdesc_if.source             wdesc,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t cfg;

    br1_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    br1_decode_core #(
        .MAX_PLANES    (MAX_PLANES),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_decode_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .body  (body),
        .wdesc (wdesc)
    );

endmodule
